/* design/run_slice_line_rasterizer_top_defines.svh */
// Assertion macros used by the checker file.
`ifndef RUN_SLICE_LINE_RASTERIZER_TOP_DEFINES_SVH
`define RUN_SLICE_LINE_RASTERIZER_TOP_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define RSL_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("rsl check failed");

// Implication whose consequent is checked in the next cycle.
`define RSL_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("rsl check failed");

`endif

/* design/rsl_pkg.sv */
`timescale 1ns / 1ps
package rsl_pkg;
    localparam int COORD_BITS = 12;
    localparam int ERR_BITS   = COORD_BITS + 3;
    localparam int ADJ_BITS   = COORD_BITS + 2;
    localparam int RUN_BITS   = COORD_BITS + 1;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    typedef enum logic [2:0]
    {
        KIND_VERT = 3'd0,
        KIND_HORZ = 3'd1,
        KIND_DIAG = 3'd2,
        KIND_XMAJ = 3'd3,
        KIND_YMAJ = 3'd4
    } kind_t;

    // Request passed from the front part to the back part.
    typedef struct packed
    {
        logic                  is_start;
        logic [COORD_BITS-1:0] x1;
        logic [COORD_BITS-1:0] y1;
        logic [COORD_BITS-1:0] x2;
        logic [COORD_BITS-1:0] y2;
        logic [23:0]           color;
    } req_t;

    typedef struct packed
    {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [23:0]           color;
        logic                  last;
    } pix_t;
endpackage

/* design/rsl_front.sv */
`timescale 1ns / 1ps
// Decode incoming requests and queue them in a two-entry FIFO.
module rsl_front
    import rsl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        in_user,
    input  logic [71:0] in_data,
    output logic        q_valid,
    input  logic        q_ready,
    output req_t        q_req
);
    req_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    req_t       dec;
    logic       push, pop;

    always_comb
    begin
        dec.is_start = (in_user == OP_START);
        dec.x1       = in_data[11:0];
        dec.y1       = in_data[23:12];
        dec.x2       = in_data[35:24];
        dec.y2       = in_data[47:36];
        // color as red, green, blue from high to low
        dec.color    = {in_data[55:48], in_data[63:56], in_data[71:64]};
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_req    = mem_reg[rp_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

/* design/rsl_back.sv */
`timescale 1ns / 1ps
// Line setup (with a restoring divider) and per-pixel stepping.
module rsl_back
    import rsl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic q_valid,
    output logic q_ready,
    input  req_t q_req,
    output logic o_valid,
    input  logic o_ready,
    output pix_t o_pix
);
    typedef enum logic [2:0]
    {
        ST_RUN   = 3'b001,
        ST_DIV   = 3'b010,
        ST_FIN   = 3'b100
    } st_t;

    localparam int CB = COORD_BITS;

    st_t                     st_reg, st_next;
    logic                    active_reg;
    kind_t                   kind_reg;
    logic [CB-1:0]           cx_reg, cy_reg;
    logic                    dir_reg;
    logic signed [ERR_BITS-1:0] err_reg;
    logic [ADJ_BITS-1:0]     up_reg, dn_reg;
    logic [CB-1:0]           base_reg, fin_reg;
    logic [RUN_BITS-1:0]     run_reg, runs_reg;
    logic [23:0]             col_reg;
    logic                    ov_reg;
    pix_t                    op_reg;
    // divider
    logic [CB-1:0]           quo_reg, rem_reg, dvs_reg, dvd_reg;
    logic [$clog2(CB+1)-1:0] cnt_reg;

    logic                    take, out_free, last, fire;
    logic [CB-1:0]           x1, y1, x2, y2, dx, dy, mj, mn;
    logic                    swp, neg;
    logic [CB:0]             trial;

    assign out_free = !ov_reg || o_ready;
    assign q_ready  = (st_reg == ST_RUN) && (q_req.is_start || !active_reg || out_free);
    assign take     = q_valid && q_ready;
    assign fire     = take && !q_req.is_start && active_reg;
    assign o_valid  = ov_reg;
    assign o_pix    = op_reg;
    assign last     = (run_reg <= RUN_BITS'(1)) && (runs_reg == '0);

    always_comb
    begin
        swp = q_req.y1 > q_req.y2;
        x1  = swp ? q_req.x2 : q_req.x1;
        y1  = swp ? q_req.y2 : q_req.y1;
        x2  = swp ? q_req.x1 : q_req.x2;
        y2  = swp ? q_req.y1 : q_req.y2;
        neg = x2 < x1;
        dx  = neg ? (x1 - x2) : (x2 - x1);
        dy  = y2 - y1;
        mj  = (dx > dy) ? dx : dy;
        mn  = (dx > dy) ? dy : dx;
        trial = {rem_reg, dvd_reg[CB-1]} - {1'b0, dvs_reg};
        st_next = st_reg;
        case (st_reg)
            ST_RUN:  if (take && q_req.is_start && dx != '0 && dy != '0 && dx != dy)
                         st_next = ST_DIV;
            ST_DIV:  if (cnt_reg == ($clog2(CB+1))'(1)) st_next = ST_FIN;
            ST_FIN:  st_next = ST_RUN;
            default: st_next = ST_RUN;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (!ov_reg || o_ready)
        begin
            op_reg <= '{x: cx_reg, y: cy_reg, color: col_reg, last: last};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_RUN; active_reg <= 1'b0; kind_reg <= KIND_VERT;
            cx_reg <= '0; cy_reg <= '0; dir_reg <= 1'b0; err_reg <= '0;
            up_reg <= '0; dn_reg <= '0; base_reg <= '0; fin_reg <= '0;
            run_reg <= '0; runs_reg <= '0; col_reg <= '0; ov_reg <= 1'b0;
            quo_reg <= '0; rem_reg <= '0; dvs_reg <= '0; dvd_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            // load a pixel on a step, hold it while the sink stalls
            ov_reg <= fire || (ov_reg && !o_ready);
            case (st_reg)
                ST_RUN:
                begin
                    if (take && q_req.is_start)
                    begin
                        active_reg <= 1'b1;
                        col_reg <= q_req.color;
                        cx_reg <= x1; cy_reg <= y1; dir_reg <= neg;
                        runs_reg <= '0; err_reg <= '0; up_reg <= '0; dn_reg <= '0;
                        base_reg <= '0; fin_reg <= '0;
                        if (dx == '0)
                        begin
                            kind_reg <= KIND_VERT;
                            run_reg <= {1'b0, dy} + 1'b1;
                        end
                        else if (dy == '0)
                        begin
                            kind_reg <= KIND_HORZ; dir_reg <= 1'b0;
                            cx_reg <= neg ? x2 : x1;
                            run_reg <= {1'b0, dx} + 1'b1;
                        end
                        else if (dx == dy)
                        begin
                            kind_reg <= KIND_DIAG;
                            run_reg <= {1'b0, dx} + 1'b1;
                        end
                        else
                        begin
                            kind_reg <= (dx > dy) ? KIND_XMAJ : KIND_YMAJ;
                            dvd_reg <= mj; dvs_reg <= mn; rem_reg <= '0;
                            quo_reg <= '0; cnt_reg <= ($clog2(CB+1))'(CB);
                            runs_reg <= {1'b0, mn};
                        end
                    end
                    else if (take && active_reg)
                    begin
                        if (last)
                        begin
                            active_reg <= 1'b0;
                        end
                        else
                        begin
                            case (kind_reg)
                                KIND_VERT:
                                begin
                                    cy_reg <= cy_reg + 1'b1; run_reg <= run_reg - 1'b1;
                                end
                                KIND_HORZ:
                                begin
                                    cx_reg <= cx_reg + 1'b1; run_reg <= run_reg - 1'b1;
                                end
                                KIND_DIAG:
                                begin
                                    cx_reg <= dir_reg ? cx_reg - 1'b1 : cx_reg + 1'b1;
                                    cy_reg <= cy_reg + 1'b1; run_reg <= run_reg - 1'b1;
                                end
                                default:
                                begin
                                    // step along the major axis; at run end step both axes, load run
                                    if (run_reg > RUN_BITS'(1))
                                    begin
                                        run_reg <= run_reg - 1'b1;
                                        if (kind_reg == KIND_XMAJ)
                                            cx_reg <= dir_reg ? cx_reg - 1'b1 : cx_reg + 1'b1;
                                        else
                                            cy_reg <= cy_reg + 1'b1;
                                    end
                                    else
                                    begin
                                        cx_reg <= dir_reg ? cx_reg - 1'b1 : cx_reg + 1'b1;
                                        cy_reg <= cy_reg + 1'b1;
                                        if (runs_reg <= RUN_BITS'(1))
                                        begin
                                            runs_reg <= '0;
                                            run_reg <= {1'b0, fin_reg};
                                        end
                                        else
                                        begin
                                            runs_reg <= runs_reg - 1'b1;
                                            if (err_reg + $signed({1'b0, up_reg}) > 0)
                                            begin
                                                run_reg <= {1'b0, base_reg} + 1'b1;
                                                err_reg <= err_reg + $signed({1'b0, up_reg})
                                                    - $signed({1'b0, dn_reg});
                                            end
                                            else
                                            begin
                                                run_reg <= {1'b0, base_reg};
                                                err_reg <= err_reg + $signed({1'b0, up_reg});
                                            end
                                        end
                                    end
                                end
                            endcase
                        end
                    end
                end
                ST_DIV:
                begin
                    // one quotient bit a cycle
                    dvd_reg <= {dvd_reg[CB-2:0], 1'b0};
                    cnt_reg <= cnt_reg - 1'b1;
                    if (!trial[CB])
                    begin
                        rem_reg <= trial[CB-1:0]; quo_reg <= {quo_reg[CB-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= {rem_reg[CB-2:0], dvd_reg[CB-1]};
                        quo_reg <= {quo_reg[CB-2:0], 1'b0};
                    end
                end
                ST_FIN:
                begin
                    base_reg <= quo_reg;
                    up_reg   <= {1'b0, rem_reg, 1'b0};
                    dn_reg   <= {1'b0, dvs_reg, 1'b0};
                    fin_reg  <= {1'b0, quo_reg[CB-1:1]} + 1'b1;
                    err_reg  <= $signed({3'b0, rem_reg}) - $signed({2'b0, dvs_reg, 1'b0})
                              + (quo_reg[0] ? $signed({3'b0, dvs_reg}) : '0);
                    run_reg  <= {2'b0, quo_reg[CB-1:1]} + 1'b1
                              - ((rem_reg == '0 && !quo_reg[0]) ? 1'b1 : 1'b0);
                end
                default: ;
            endcase
        end
    end
endmodule

/* design/run_slice_line_rasterizer_top.sv */
`timescale 1ns / 1ps
// Run-slice Bresenham line rasterizer. A start request (op = 0 on tuser) loads
// two endpoints and a color and gives no pixel; each step request (op = 1)
// gives one pixel, tlast marking the line's end. A step with no line drawing
// gives nothing. Steps flow at one per cycle while the output is not stalled
// and no divide runs. A start of a vertical, horizontal or diagonal line is
// set up directly; a general line then passes ST_DIV, where the
// one-bit-per-cycle divider forms the whole step, and ST_FIN, which finishes
// the run terms. A two-entry request queue sits in front.
module run_slice_line_rasterizer_top
    import rsl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // op
    input  logic        s_axis_tuser,
    // x_start, y_start, x_end, y_end, red_in, green_in, blue_in
    input  logic [71:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // pixel_x, pixel_y, red_out, green_out, blue_out
    output logic [47:0] m_axis_tdata,
    output logic        m_axis_tlast
);
    logic q_valid, q_ready;
    req_t q_req;
    pix_t pix;

    rsl_front u_front
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_user(s_axis_tuser), .in_data(s_axis_tdata),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
    );

    rsl_back u_back
    (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
        .o_valid(m_axis_tvalid), .o_ready(m_axis_tready), .o_pix(pix)
    );

    assign m_axis_tdata = {pix.color[7:0], pix.color[15:8], pix.color[23:16], pix.y, pix.x};
    assign m_axis_tlast = pix.last;
endmodule

/* design/rsl_checker.sv */
`timescale 1ns / 1ps
`include "run_slice_line_rasterizer_top_defines.svh"
module rsl_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic        m_axis_tlast
);
    `RSL_ASSERT_NEXT(a_hold_valid, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `RSL_ASSERT_NEXT(a_hold_data, clk, rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tlast))
    `RSL_ASSERT_IMP(a_out_known, clk, rst_n, m_axis_tvalid, !$isunknown({m_axis_tdata, m_axis_tlast}))
    `RSL_ASSERT_IMP(a_ready_known, clk, rst_n, s_axis_tvalid, !$isunknown(s_axis_tready))
endmodule

bind run_slice_line_rasterizer_top rsl_checker u_rsl_checker
(
    .clk(clk), .rst_n(rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);
